/* hw/rtl/bpm_pkg.sv */
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the pixelate mosaic block: the item formats
// of both channels, register indexes and the geometry limits.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Geometry limits.
  localparam int MAX_WIDTH = 2048;
  localparam int MAX_BLOCK = 64;

  // Derived widths.
  localparam int COL_W   = $clog2(MAX_WIDTH);   // column position, store address
  localparam int BLK_W   = $clog2(MAX_BLOCK);   // position inside a block
  localparam int PIX_W   = 24;
  localparam int BSIZE_W = 7;
  localparam int IWID_W  = 12;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

  // Incoming pixel item.
  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  // Result pixel item.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
  } pix_out_t;

  // Per-pixel decision from the position tracker.
  typedef struct packed {
    logic             store_wr;   // first row of a band, first column of a block
    logic             store_rd;   // later row of a band, first column of a block
    logic [COL_W-1:0] slot;       // store address for this pixel
    logic             last;       // last pixel of its row
  } pos_t;

endpackage

/* hw/rtl/block_pixelate_mosaic.sv */
// ----------------------------------------------------------------------------
// block_pixelate_mosaic
// Pixelate (mosaic) filter for a raster stream of 24-bit RGB pixels. Every
// square block of block_size by block_size pixels is replaced by its
// top-left pixel; partial blocks at the right and bottom edges likewise.
//
// Input items enter on in_valid/in_stall with in_data; a pixel with
// frame_start set clears the position counters before it is placed.
// Result items leave on out_valid/out_stall with out_data, one per input
// item and in the same order; row_end marks the last pixel of each row.
// One item is taken every cycle unless in_stall is high: the counters, the
// single port of the line store and the output register each handle one
// pixel per clock. The user must write block_size and image_width on
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does
// not enforce this. Reset sets them to 2 and 640 and clears the counters,
// the held pixel and both pipeline stages; the line store is not cleared,
// as each entry is written on the first row of a band before it is read.
// When the receiver stalls, the output register holds its item and the
// stall reaches in_stall once the middle stage is occupied too.
// ----------------------------------------------------------------------------
module block_pixelate_mosaic (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpm_pkg::pix_in_t            in_data,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output bpm_pkg::pix_out_t           out_data,
  // Configuration port
  input  logic                        cfg_we,
  input  logic [bpm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bpm_pkg::CFG_W-1:0]   cfg_wdata
);
  import bpm_pkg::*;

  logic [BSIZE_W-1:0] block_size_r;
  logic [IWID_W-1:0]  image_width_r;

  logic               accept;
  logic               out_free;
  logic               s1_move;
  pos_t               pos;
  logic [PIX_W-1:0]   in_pix;
  logic [PIX_W-1:0]   rd_data;

  logic               s1_valid_r;
  logic               s1_wr_r;
  logic               s1_rd_r;
  logic               s1_last_r;
  logic [PIX_W-1:0]   s1_pix_r;

  logic [PIX_W-1:0]   held_r, held_nxt;
  logic               out_valid_r;
  pix_out_t           out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= BSIZE_W'(2);
      image_width_r <= IWID_W'(640);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:  block_size_r  <= cfg_wdata[BSIZE_W-1:0];
        REG_IMAGE_WIDTH: image_width_r <= cfg_wdata[IWID_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the middle stage moves when the output register is free.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign in_pix = {in_data.red, in_data.green, in_data.blue};

  bpm_position u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_data.frame_start),
    .block_size  (block_size_r),
    .image_width (image_width_r),
    .pos         (pos)
  );

  bpm_store u_store (
    .clk     (clk),
    .wr_en   (accept && pos.store_wr),
    .rd_en   (accept && pos.store_rd),
    .addr    (pos.slot),
    .wr_data (in_pix),
    .rd_data (rd_data)
  );

  // Middle stage: waits for the store read of its item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r   <= pos.store_wr;
      s1_rd_r   <= pos.store_rd;
      s1_last_r <= pos.last;
      s1_pix_r  <= in_pix;
    end
  end

  // New held pixel: captured, read back from the store, or kept.
  always_comb begin
    if (s1_wr_r) begin
      held_nxt = s1_pix_r;
    end else if (s1_rd_r) begin
      held_nxt = rd_data;
    end else begin
      held_nxt = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s1_move) begin
      held_r <= held_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.out_red   <= held_nxt[23:16];
      out_data_r.out_green <= held_nxt[15:8];
      out_data_r.out_blue  <= held_nxt[7:0];
      out_data_r.row_end   <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/bpm_position.sv */
// ----------------------------------------------------------------------------
// bpm_position
// Raster position tracker. Keeps the column and the place inside the current
// mosaic block, and tells for the pixel on the input whether the line store
// is written, read or left alone.
// ----------------------------------------------------------------------------
module bpm_position (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        frame_start,
  input  logic [bpm_pkg::BSIZE_W-1:0] block_size,
  input  logic [bpm_pkg::IWID_W-1:0]  image_width,
  output bpm_pkg::pos_t               pos
);
  import bpm_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [BLK_W-1:0] cib_r, cib_nxt;
  logic [BLK_W-1:0] rib_r, rib_nxt;
  logic [COL_W-1:0] col_cur;
  logic [BLK_W-1:0] cib_cur;
  logic [BLK_W-1:0] rib_cur;
  logic [BLK_W-1:0] blk_lim;
  logic [COL_W-1:0] col_lim;
  logic             last;

  // Last position inside a block, with zero and oversize codes clamped.
  always_comb begin
    if (block_size == '0) begin
      blk_lim = '0;
    end else if (block_size > BSIZE_W'(MAX_BLOCK)) begin
      blk_lim = BLK_W'(MAX_BLOCK - 1);
    end else begin
      blk_lim = BLK_W'(block_size - BSIZE_W'(1));
    end
  end

  // Last column of a row, with zero and oversize widths clamped.
  always_comb begin
    if (image_width == '0) begin
      col_lim = '0;
    end else if (image_width > IWID_W'(MAX_WIDTH)) begin
      col_lim = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_lim = COL_W'(image_width - IWID_W'(1));
    end
  end

  // A frame start clears the counters before this pixel is placed.
  always_comb begin
    if (frame_start) begin
      col_cur = '0;
      cib_cur = '0;
      rib_cur = '0;
    end else begin
      col_cur = col_r;
      cib_cur = cib_r;
      rib_cur = rib_r;
    end
  end

  // Decision for the current pixel.
  always_comb begin
    last         = (col_cur >= col_lim);
    pos.store_wr = (cib_cur == '0) && (rib_cur == '0);
    pos.store_rd = (cib_cur == '0) && (rib_cur != '0);
    pos.slot     = col_cur;
    pos.last     = last;
  end

  // Counter advance; "at or past" compares keep mid-frame changes safe.
  always_comb begin
    if (last) begin
      col_nxt = '0;
      cib_nxt = '0;
      rib_nxt = (rib_cur >= blk_lim) ? '0 : rib_cur + BLK_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      cib_nxt = (cib_cur >= blk_lim) ? '0 : cib_cur + BLK_W'(1);
      rib_nxt = rib_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      cib_r <= '0;
      rib_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      cib_r <= cib_nxt;
      rib_r <= rib_nxt;
    end
  end

endmodule

/* hw/rtl/bpm_store.sv */
// ----------------------------------------------------------------------------
// bpm_store
// Line store with one entry per image column. Holds the top-left pixel of
// every block of the current band. One write or one read per cycle, read
// data registered.
// ----------------------------------------------------------------------------
module bpm_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      rd_en,
  input  logic [bpm_pkg::COL_W-1:0] addr,
  input  logic [bpm_pkg::PIX_W-1:0] wr_data,
  output logic [bpm_pkg::PIX_W-1:0] rd_data
);
  import bpm_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* test/mosaic_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mosaic_checker
// Watches the input, result and register ports of the pixelate mosaic
// block. It keeps its own copy of the position counters, the held pixel and
// the line store, works out the mosaic pixel for every accepted input item
// and compares each accepted result item field by field, in order.
// ----------------------------------------------------------------------------
module mosaic_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  bpm_pkg::pix_in_t            in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  bpm_pkg::pix_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [bpm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bpm_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          checked,
  output int                          row_ends
);
  import bpm_pkg::*;

  // Register copies as last written.
  logic [BSIZE_W-1:0] blk_size;
  logic [IWID_W-1:0]  img_width;

  // Position within the frame and the pixel currently being replicated.
  logic [COL_W-1:0]   col_pos;
  logic [BLK_W-1:0]   col_in_blk;
  logic [BLK_W-1:0]   row_in_blk;
  logic [PIX_W-1:0]   held_rgb;
  logic [PIX_W-1:0]   line_store [MAX_WIDTH];

  pix_out_t           expected_pixels [$];
  pix_out_t           want_pix;

  // Places one pixel in the frame and returns the mosaic pixel it becomes.
  function automatic pix_out_t place_pixel(input pix_in_t px);
    int       bs;
    int       w;
    logic     last_col;
    pix_out_t res;
    bs = (blk_size == 0) ? 1 : ((blk_size > MAX_BLOCK) ? MAX_BLOCK : int'(blk_size));
    w  = (img_width == 0) ? 1 : ((img_width > MAX_WIDTH) ? MAX_WIDTH : int'(img_width));
    if (px.frame_start) begin
      col_pos    = '0;
      col_in_blk = '0;
      row_in_blk = '0;
    end
    // The first column of a block either captures or recalls its top-left pixel.
    if (col_in_blk == 0) begin
      if (row_in_blk == 0) begin
        line_store[col_pos] = {px.red, px.green, px.blue};
        held_rgb            = {px.red, px.green, px.blue};
      end else begin
        held_rgb = line_store[col_pos];
      end
    end
    // A row ends at or past its last column, so a narrowed width ends it at once.
    last_col      = int'(col_pos) >= w - 1;
    res.out_red   = held_rgb[23:16];
    res.out_green = held_rgb[15:8];
    res.out_blue  = held_rgb[7:0];
    res.row_end   = last_col;
    if (last_col) begin
      col_pos    = '0;
      col_in_blk = '0;
      row_in_blk = (int'(row_in_blk) >= bs - 1) ? '0 : row_in_blk + 1'b1;
    end else begin
      col_pos    = col_pos + 1'b1;
      col_in_blk = (int'(col_in_blk) >= bs - 1) ? '0 : col_in_blk + 1'b1;
    end
    return res;
  endfunction

  // Reports one field that differs from its expected value.
  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Track registers and input items, and check result items against the
  // oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      blk_size   = 7'd2;
      img_width  = 12'd640;
      col_pos    = '0;
      col_in_blk = '0;
      row_in_blk = '0;
      held_rgb   = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_SIZE:  blk_size  = cfg_wdata[BSIZE_W-1:0];
          REG_IMAGE_WIDTH: img_width = cfg_wdata[IWID_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(place_pixel(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with no pixel expected: %h", out_data);
          fail_count++;
        end else begin
          want_pix = expected_pixels.pop_front();
          checked++;
          if (out_data.row_end === 1'b1) begin
            row_ends++;
          end
          compare_field("out_red", want_pix.out_red, out_data.out_red);
          compare_field("out_green", want_pix.out_green, out_data.out_green);
          compare_field("out_blue", want_pix.out_blue, out_data.out_blue);
          compare_field("row_end", {7'd0, want_pix.row_end}, {7'd0, out_data.row_end});
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the pixelate mosaic block. After reset a few extreme colours
// run under the reset settings, then a short row with single-pixel blocks
// under a saturated width. Directed settings follow for saturated and zero
// registers and a width narrowed in the middle of a frame, then random
// settings with random pixels, each opening a new frame. Both channels idle
// at random but in the last third of the random run; the checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
  import bpm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 350;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  pix_in_t            in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pix_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [IDX_W-1:0]   cfg_index = REG_BLOCK_SIZE;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int send_gap_pct = 26;
  int stall_pct    = 60;
  int fail_count;
  int pending;
  int checked;
  int row_ends;
  int cycle_count    = 0;
  int settings_used  = 0;
  int pixels_sent    = 0;
  int random_sent    = 0;

  logic [PIX_W-1:0] extreme_colours [12] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAA55AA,
    24'h55AA55, 24'h010203, 24'h808080, 24'h7F7F7F, 24'hFEFDFC, 24'h123456
  };

  always #5 clk = ~clk;

  block_pixelate_mosaic i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mosaic_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .row_ends   (row_ends)
  );

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL block_pixelate_mosaic");
      $finish;
    end
  end

  // Idle rates: sender light and receiver heavy, then the reverse, then none.
  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_gap_pct = 26;
        stall_pct    = 60;
      end
      1: begin
        send_gap_pct = 60;
        stall_pct    = 26;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
  endtask

  // Offers one item and returns at the falling edge after it was taken.
  task automatic push_pixel(input pix_in_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  function automatic pix_in_t random_pixel(input int start_pct);
    pix_in_t px;
    px.frame_start = ($urandom_range(99) < start_pct);
    px.red         = 8'($urandom_range(255));
    px.green       = 8'($urandom_range(255));
    px.blue        = 8'($urandom_range(255));
    return px;
  endfunction

  // Waits until every result is out, then writes both registers.
  task automatic apply_setting(input logic [CFG_W-1:0] bs_word,
                               input logic [CFG_W-1:0] width_word);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_wdata <= bs_word;
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= width_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  initial begin
    pix_in_t          px;
    int               n;
    logic [CFG_W-1:0] bs_word;
    logic [CFG_W-1:0] width_word;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    set_idle_mode(0);

    // Reset settings with counters fresh from reset; a frame start part way.
    foreach (extreme_colours[i]) begin
      px.frame_start = (i == 7);
      {px.red, px.green, px.blue} = extreme_colours[i];
      push_pixel(px);
    end

    // Block size zero acts as one and an oversized width as the maximum:
    // every pixel opens a block of its own and the row does not end.
    apply_setting(12'd0, 12'd4095);
    for (int k = 0; k < 40; k++) begin
      px = random_pixel(0);
      px.frame_start = (k == 0);
      push_pixel(px);
    end

    // Oversized block with width zero: every pixel is a row of its own.
    apply_setting(12'd127, 12'd0);
    for (int k = 0; k < 70; k++) begin
      px = random_pixel(0);
      px.frame_start = (k == 0);
      push_pixel(px);
    end

    // Width narrowed in the middle of a row: that row ends at once.
    apply_setting(12'd3, 12'd10);
    for (int k = 0; k < 25; k++) begin
      px = random_pixel(0);
      px.frame_start = (k == 0);
      push_pixel(px);
    end
    apply_setting(12'd3, 12'd4);
    for (int k = 0; k < 10; k++) begin
      push_pixel(random_pixel(0));
    end

    // Random settings, mostly small, each opening a new frame.
    while (random_sent < RANDOM_PIXELS) begin
      set_idle_mode(random_sent * 3 / RANDOM_PIXELS);
      bs_word = CFG_W'($urandom_range(4095));
      case ($urandom_range(9))
        0:       bs_word[BSIZE_W-1:0] = 7'd0;
        1:       bs_word[BSIZE_W-1:0] = 7'd1;
        2:       bs_word[BSIZE_W-1:0] = 7'(MAX_BLOCK);
        3:       bs_word[BSIZE_W-1:0] = 7'($urandom_range(MAX_BLOCK + 1, 127));
        default: bs_word[BSIZE_W-1:0] = 7'($urandom_range(2, 8));
      endcase
      case ($urandom_range(11))
        0:       width_word = 12'd0;
        1:       width_word = 12'd1;
        2:       width_word = 12'(MAX_WIDTH);
        3:       width_word = 12'($urandom_range(MAX_WIDTH + 1, 4095));
        default: width_word = 12'($urandom_range(2, 40));
      endcase
      apply_setting(bs_word, width_word);
      n = $urandom_range(25, 60);
      for (int k = 0; k < n; k++) begin
        px = random_pixel(2);
        if (k == 0) begin
          px.frame_start = 1'b1;
        end
        push_pixel(px);
        random_sent++;
      end
    end

    // Drain, then allow for the pipeline latency.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Mosaic run: %0d pixels under %0d register settings, block sizes 0 to 127,",
             pixels_sent, settings_used);
    $display("widths 0 to 4095 and mid-frame changes; %0d results compared, %0d row ends.",
             checked, row_ends);
    if (fail_count == 0) begin
      $display("PASS block_pixelate_mosaic");
    end else begin
      $display("FAIL block_pixelate_mosaic");
    end
    $finish;
  end

endmodule
